// ----- rtl/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Operation codes, status codes, controller states and field widths.
// ----------------------------------------------------------------------------
package krt_pkg;

	// Widths of the request and response fields.
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Operation carried by a request transaction.
	typedef enum logic [FUNC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_UPDATE = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	// Status returned with every response transaction.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_ABSENT  = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

// ----- rtl/krt_ram.sv -----
// ----------------------------------------------------------------------------
// krt_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module krt_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/keyed_record_table.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table: packed key/value table with linear search
// Holds up to ENTRIES unique key/value pairs in insertion order. Requests
// insert, look up, update or remove a key; removal compacts the table.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  request  | req_valid / req_ready  | func, key, value
//  response | rsp_valid / rsp_ready  | status, value_out, entry_count
//
// A scan stops at the slot that holds the key, or once every stored key has
// been compared when it is missing. Keys are scanned one per cycle through the
// key RAM read port, with values alongside. A remove of a slot then shifts
// the later entries: they move down one slot per cycle through the read and
// write ports. Reset clears the entry count; the RAMs are not cleared.
// A request is taken only while the controller is idle; a finished response
// waits in the output register while the next request is accepted.
module keyed_record_table #(
	parameter int ENTRIES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [krt_pkg::FUNC_W-1:0]          func,
	input  logic signed [krt_pkg::KEY_W-1:0]    key,
	input  logic [krt_pkg::VALUE_W-1:0]         value,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [krt_pkg::STAT_W-1:0]          status,
	output logic [krt_pkg::VALUE_W-1:0]         value_out,
	output logic [krt_pkg::COUNT_W-1:0]         entry_count
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	krt_pkg::state_t  state_q, state_d;
	krt_pkg::op_t     func_q;
	logic [krt_pkg::KEY_W-1:0]   key_q;
	logic [krt_pkg::VALUE_W-1:0] value_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;

	// Compare stage of the scan and write stage of the shift.
	logic             cmp_v_s1;
	logic [AW-1:0]    cmp_idx_s1;
	logic             sh_v_s1;
	logic [AW-1:0]    sh_idx_s1;

	// Result waiting for the output register.
	krt_pkg::status_t res_status_q;
	logic [krt_pkg::VALUE_W-1:0] res_value_q;

	// Output register.
	logic             rsp_valid_q;
	krt_pkg::status_t status_q;
	logic [krt_pkg::VALUE_W-1:0] value_out_q;
	logic [krt_pkg::COUNT_W-1:0] entry_count_q;

	// Memory ports and controller decisions.
	logic             issue;
	logic             hit;
	logic             resolved;
	logic             rsp_load;
	logic             kwe, vwe;
	logic [AW-1:0]    waddr;
	logic [krt_pkg::KEY_W-1:0]   kwdata, key_rdata;
	logic [krt_pkg::VALUE_W-1:0] vwdata, val_rdata;

	krt_ram #(.WIDTH(krt_pkg::KEY_W), .DEPTH(ENTRIES), .ADDR_W(AW)) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (waddr),
		.wdata (kwdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (key_rdata)
	);

	krt_ram #(.WIDTH(krt_pkg::VALUE_W), .DEPTH(ENTRIES), .ADDR_W(AW)) u_val_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (waddr),
		.wdata (vwdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (val_rdata)
	);

	// A scan hits when the key read last cycle matches; it misses once every
	// stored key has been compared.
	assign hit      = cmp_v_s1 && (key_rdata == key_q);
	assign resolved = hit || (!cmp_v_s1 && (idx_q == count_q));

	// Next state, memory writes and read issue.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		issue     = 1'b0;
		kwe       = 1'b0;
		vwe       = 1'b0;
		waddr     = '0;
		kwdata    = key_q;
		vwdata    = value_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			krt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = krt_pkg::S_SCAN;
				end
			end
			krt_pkg::S_SCAN: begin
				issue = !hit && (idx_q < count_q);
				if (resolved) begin
					case (func_q)
						krt_pkg::OP_INSERT: begin
							if (!hit && (count_q != CW'(ENTRIES))) begin
								kwe   = 1'b1;
								vwe   = 1'b1;
								waddr = count_q[AW-1:0];
							end
						end
						krt_pkg::OP_UPDATE: begin
							if (hit) begin
								vwe   = 1'b1;
								waddr = cmp_idx_s1;
							end
						end
						default: begin
						end
					endcase
					if ((func_q == krt_pkg::OP_REMOVE) && hit) begin
						state_d = krt_pkg::S_SHIFT;
					end else begin
						state_d = krt_pkg::S_DONE;
					end
				end
			end
			krt_pkg::S_SHIFT: begin
				issue  = idx_q < count_q;
				kwe    = sh_v_s1;
				vwe    = sh_v_s1;
				waddr  = sh_idx_s1;
				kwdata = key_rdata;
				vwdata = val_rdata;
				if (!issue && !sh_v_s1) begin
					state_d = krt_pkg::S_DONE;
				end
			end
			krt_pkg::S_DONE: begin
				rsp_load = !rsp_valid_q || rsp_ready;
				if (rsp_load) begin
					state_d = krt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = krt_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: read pointer, entry count and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			cmp_v_s1    <= 1'b0;
			sh_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == krt_pkg::S_SCAN) && issue;
			sh_v_s1  <= (state_q == krt_pkg::S_SHIFT) && issue;
			if (req_valid && req_ready) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end else if ((state_q == krt_pkg::S_SCAN) && hit) begin
				// A remove continues by moving the entry above the slot down.
				idx_q <= CW'(cmp_idx_s1) + 1'b1;
			end
			if ((state_q == krt_pkg::S_SCAN) && resolved && !hit
					&& (func_q == krt_pkg::OP_INSERT) && (count_q != CW'(ENTRIES))) begin
				count_q <= count_q + 1'b1;
			end else if ((state_q == krt_pkg::S_SHIFT) && (state_d == krt_pkg::S_DONE)) begin
				count_q <= count_q - 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request fields, stage addresses and results.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_q  <= krt_pkg::op_t'(func);
			key_q   <= $unsigned(key);
			value_q <= value;
		end
		cmp_idx_s1 <= idx_q[AW-1:0];
		sh_idx_s1  <= idx_q[AW-1:0] - 1'b1;
		if ((state_q == krt_pkg::S_SCAN) && resolved) begin
			res_value_q <= '0;
			case (func_q)
				krt_pkg::OP_INSERT: begin
					if (hit) begin
						res_status_q <= krt_pkg::STAT_PRESENT;
					end else if (count_q == CW'(ENTRIES)) begin
						res_status_q <= krt_pkg::STAT_FULL;
					end else begin
						res_status_q <= krt_pkg::STAT_OK;
					end
				end
				krt_pkg::OP_LOOKUP: begin
					res_status_q <= hit ? krt_pkg::STAT_OK : krt_pkg::STAT_ABSENT;
					if (hit) begin
						res_value_q <= val_rdata;
					end
				end
				default: begin
					res_status_q <= hit ? krt_pkg::STAT_OK : krt_pkg::STAT_ABSENT;
				end
			endcase
		end
		if (rsp_load) begin
			status_q      <= res_status_q;
			value_out_q   <= res_value_q;
			entry_count_q <= krt_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;

	// The table never holds more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count exceeds capacity");

	// A shift write always lands on a slot that holds a live entry.
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sh_v_s1 |-> (CW'(sh_idx_s1) < count_q))
		else $error("shift write outside the packed entries");

	// The compare stage is only live while scanning.
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> (state_q == krt_pkg::S_SCAN))
		else $error("key compare outside a scan");

	// A new response appears only after the controller finished a request.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == krt_pkg::S_DONE))
		else $error("response raised without a finished request");

	// A removal leaves exactly one entry fewer.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == krt_pkg::S_SHIFT) && (state_d == krt_pkg::S_DONE))
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("remove did not shrink the table by one");

endmodule
